FILE: src/firlp_pkg.sv
// ----------------------------------------------------------------------------
// FIR low-pass package
// Shared widths, coefficient reset values and the sequencer control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package firlp_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W      = 14;
    localparam int COEF_W        = 16;
    localparam int CFG_IDX_W     = 8;
    localparam int NUM_COEF_REGS = 8;

    // Product of an unsigned sample (zero-extended) and a signed coefficient.
    localparam int PROD_W = SAMPLE_W + 1 + COEF_W;

    // Defaults for the top-level parameters.
    localparam int TAPS_DEF      = 8;
    localparam int FRAC_BITS_DEF = 15;

    // Upper clamp of the output, in millivolts.
    localparam logic [SAMPLE_W-1:0] OUT_MAX = 14'd9999;

    // 2 kHz low-pass set, oldest tap first.
    localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEF_REGS] = '{
        16'sd287, 16'sd1571, 16'sd5375, 16'sd9151,
        16'sd9151, 16'sd5375, 16'sd1571, 16'sd287
    };

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic idle;      // ready for a new item
        logic shift_in;  // new sample enters the delay line
        logic rotate;    // delay line turns by one tap
        logic mul_en;    // multiply head sample by the current coefficient
        logic acc_clr;   // start a fresh sum
        logic load_out;  // move the finished result into the output register
    } t_seq_ctrl;

endpackage

`default_nettype wire

FILE: src/firlp_coef_regs.sv
// ----------------------------------------------------------------------------
// FIR coefficient registers
// Holds the writable Q1.15 coefficients and selects the one for the current tap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firlp_coef_regs #(
    parameter int TAPS = firlp_pkg::TAPS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    input  wire logic [firlp_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [firlp_pkg::COEF_W-1:0]         i_cfg_data,
    input  wire logic [$clog2(TAPS)-1:0]              i_tap,
    output logic signed [firlp_pkg::COEF_W-1:0]       o_coef
);

    localparam int NCOEF = (TAPS < firlp_pkg::NUM_COEF_REGS) ? TAPS
                                                             : firlp_pkg::NUM_COEF_REGS;
    localparam int IDX_W = $clog2(NCOEF);
    localparam int CNT_W = $clog2(TAPS);

    logic signed [firlp_pkg::COEF_W-1:0] r_coef [NCOEF];
    logic                                w_wr_ok;

    // A write beyond the stored coefficients is dropped.
    assign w_wr_ok = i_cfg_valid &&
                     (i_cfg_index < firlp_pkg::CFG_IDX_W'(NCOEF));

    // Coefficient storage, reset to the low-pass set.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NCOEF; k++) begin
            if (!i_rst_n) begin
                r_coef[k] <= firlp_pkg::COEF_RESET[k];
            end else if (w_wr_ok && (i_cfg_index[IDX_W-1:0] == IDX_W'(k))) begin
                r_coef[k] <= $signed(i_cfg_data);
            end
        end
    end

    // Taps above the stored set carry a zero coefficient.
    always_comb begin
        if ({1'b0, i_tap} < (CNT_W + 1)'(NCOEF)) begin
            o_coef = r_coef[i_tap[IDX_W-1:0]];
        end else begin
            o_coef = '0;
        end
    end

endmodule

`default_nettype wire

FILE: src/firlp_delay_line.sv
// ----------------------------------------------------------------------------
// FIR delay line
// Sample history that shifts in new items and rotates past the multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firlp_delay_line #(
    parameter int TAPS = firlp_pkg::TAPS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire firlp_pkg::t_seq_ctrl               i_ctrl,
    input  wire logic [firlp_pkg::SAMPLE_W-1:0]     i_sample,
    output logic [firlp_pkg::SAMPLE_W-1:0]          o_head
);

    logic [firlp_pkg::SAMPLE_W-1:0] r_line [TAPS];
    logic [firlp_pkg::SAMPLE_W-1:0] w_fill;

    // The top entry takes either the new sample or the old head when rotating.
    assign w_fill = i_ctrl.shift_in ? i_sample : r_line[0];

    // Between items entry 0 holds the oldest sample; a full rotation restores the order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_line[t] <= '0;
            end
        end else if (i_ctrl.shift_in || i_ctrl.rotate) begin
            for (int t = 0; t < TAPS - 1; t++) begin
                r_line[t] <= r_line[t+1];
            end
            r_line[TAPS-1] <= w_fill;
        end
    end

    assign o_head = r_line[0];

endmodule

`default_nettype wire

FILE: src/firlp_mac.sv
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// One registered multiplier feeding an accumulator, with scaling and clamping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firlp_mac #(
    parameter int TAPS           = firlp_pkg::TAPS_DEF,
    parameter int COEF_FRAC_BITS = firlp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire firlp_pkg::t_seq_ctrl                i_ctrl,
    input  wire logic [firlp_pkg::SAMPLE_W-1:0]      i_sample,
    input  wire logic signed [firlp_pkg::COEF_W-1:0] i_coef,
    output logic [firlp_pkg::SAMPLE_W-1:0]           o_result
);

    localparam int PROD_W = firlp_pkg::PROD_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

    logic signed [firlp_pkg::SAMPLE_W:0] w_sample_s;
    logic signed [PROD_W-1:0]            r_prod;
    logic                                r_prod_vld;
    logic signed [ACC_W-1:0]             r_acc;
    logic [ACC_W-1:0]                    w_scaled;

    assign w_sample_s = $signed({1'b0, i_sample});

    // Multiplier stage; the product is registered before it is summed.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= w_sample_s * i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= i_ctrl.mul_en;
        end
    end

    // Accumulator, cleared when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Drop the fraction, then clamp to the millivolt range.
    assign w_scaled = $unsigned(r_acc) >> COEF_FRAC_BITS;

    always_comb begin
        if (r_acc[ACC_W-1]) begin
            o_result = '0;
        end else if (w_scaled > ACC_W'(firlp_pkg::OUT_MAX)) begin
            o_result = firlp_pkg::OUT_MAX;
        end else begin
            o_result = w_scaled[firlp_pkg::SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

FILE: src/firlp_seq.sv
// ----------------------------------------------------------------------------
// FIR sequencer
// Steps the shared multiplier over every tap and hands the result to the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firlp_seq #(
    parameter int TAPS = firlp_pkg::TAPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire logic                       i_out_free,
    output firlp_pkg::t_seq_ctrl            o_ctrl,
    output logic [$clog2(TAPS)-1:0]         o_tap
);

    localparam int CNT_W = $clog2(TAPS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_last;

    assign w_last = (r_cnt == CNT_W'(TAPS - 1));

    // Next state and control decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.idle = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.shift_in = 1'b1;
                    o_ctrl.acc_clr  = 1'b1;
                    n_cnt           = '0;
                    n_state         = S_RUN;
                end
            end
            S_RUN: begin
                o_ctrl.mul_en = 1'b1;
                o_ctrl.rotate = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (w_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last product is summed in this cycle.
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_tap = r_cnt;

endmodule

`default_nettype wire

FILE: src/fir_lowpass_8tap.sv
// ----------------------------------------------------------------------------
// Eight-tap FIR low-pass filter
// Filters millivolt samples with writable Q1.15 coefficients on one multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_stall   i_sample_mv (14 bit)
//  output    out        o_out_valid / i_out_stall o_filtered_mv (14 bit)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each item is accepted, passed tap by tap through the shared multiplier, and
// its last product is summed before the result is loaded into the output
// register; the load waits while a stalled result still holds that register.
// Reset restores the low-pass coefficients and clears the delay line.
// A stalled result waits in the output register while the next item is taken.
// Coefficient writes are taken only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fir_lowpass_8tap #(
    parameter int TAPS           = firlp_pkg::TAPS_DEF,
    parameter int COEF_FRAC_BITS = firlp_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [firlp_pkg::SAMPLE_W-1:0]   i_sample_mv,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [firlp_pkg::SAMPLE_W-1:0]        o_filtered_mv,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [firlp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [firlp_pkg::COEF_W-1:0]     i_cfg_data
);

    firlp_pkg::t_seq_ctrl                w_ctrl;
    logic [$clog2(TAPS)-1:0]             w_tap;
    logic [firlp_pkg::SAMPLE_W-1:0]      w_head;
    logic signed [firlp_pkg::COEF_W-1:0] w_coef;
    logic [firlp_pkg::SAMPLE_W-1:0]      w_result;
    logic                                w_out_free;
    logic                                r_out_valid;
    logic [firlp_pkg::SAMPLE_W-1:0]      r_out_data;

    // The output register is free when empty or being taken this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;

    firlp_seq #(
        .TAPS (TAPS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl),
        .o_tap      (w_tap)
    );

    firlp_delay_line #(
        .TAPS (TAPS)
    ) u_delay_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (i_sample_mv),
        .o_head   (w_head)
    );

    firlp_coef_regs #(
        .TAPS (TAPS)
    ) u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tap       (w_tap),
        .o_coef      (w_coef)
    );

    firlp_mac #(
        .TAPS           (TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_sample (w_head),
        .i_coef   (w_coef),
        .o_result (w_result)
    );

    // Output register, set on load and cleared once the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_out_data <= w_result;
        end
    end

    assign o_in_stall    = !w_ctrl.idle;
    assign o_out_valid   = r_out_valid;
    assign o_filtered_mv = r_out_data;
    assign o_cfg_ready   = w_ctrl.idle;

endmodule

`default_nettype wire
